// ===== rtl/cse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the counting sort engine
// Request/response payload structs, sequencer states and size defaults.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int KEY_W             = 12;
   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_RANGE_DEFAULT = 4096;

   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             last_key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_value;
      logic             last_out;
      logic             overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,     // taking keys
      ST_PREFIX,   // running sum over the count store
      ST_SC_KEY,   // scatter: fetch buffered key
      ST_SC_CNT,   // scatter: fetch its count
      ST_SC_PUT,   // scatter: place key, decrement count
      ST_EMIT,     // stream sorted keys out
      ST_CLEAR     // zero the count store
   } state_type;

endpackage

// ===== rtl/counting_sort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_sort_engine: stable counting sort of a set of unsigned keys
// Counts keys into a count store, forms prefix sums, scatters the buffered
// keys from last to first and streams the set out in ascending order.
// ----------------------------------------------------------------------------
//
//  channel   ports                       direction  handshake
//  --------  --------------------------  ---------  --------------------------
//  request   start, busy, req_data       in         taken when start & !busy
//  response  rsp_strobe, rsp_data        out        one key per cycle, no stall
//
//  Keys are taken one per cycle while idle. The request marked last_key
//  starts the sort; busy stays high until the set is out and the count store
//  is clean again. With S = min(KEY_RANGE, 4096) count slots, a sort walks S
//  slots for prefix sums, scatters each buffered key via ST_SC_KEY, ST_SC_CNT
//  and ST_SC_PUT, emits the keys and sweeps S slots clear, paced by the single
//  port pair of the count store. After reset the block runs that clear sweep
//  before the first request. Responses cannot be held off by the receiver.
//
module counting_sort_engine #(
   parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_RANGE = cse_pkg::KEY_RANGE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cse_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cse_pkg::rsp_type rsp_data
);

   // keys wider than the field can never arrive, so the store stops there
   localparam int KEY_SLOTS = (KEY_RANGE < (1 << cse_pkg::KEY_W)) ?
                              KEY_RANGE : (1 << cse_pkg::KEY_W);
   localparam int AW = $clog2(KEY_SLOTS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = $clog2(MAX_ITEMS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(KEY_SLOTS - 1);

   // ---------------------------------------------------------------- state
   cse_pkg::state_type state_ff, state_in;
   logic [CW-1:0] item_cnt_ff, item_cnt_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] walk_ff, walk_in;        // prefix issue / clear sweep index
   logic          pf_end_ff, pf_end_in;    // all prefix reads issued
   logic [CW-1:0] acc_ff, acc_in;          // running prefix sum
   logic          st_vld_ff, st_vld_in;    // count read in flight for update
   logic          st_pf_ff, st_pf_in;      // 1: prefix update, 0: key increment
   logic [AW-1:0] st_addr_ff, st_addr_in;
   logic [IW-1:0] sc_idx_ff, sc_idx_in;
   logic [IW-1:0] em_idx_ff, em_idx_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // ---------------------------------------------------------------- memories
   logic [CW-1:0] cs_mem [KEY_SLOTS];      // count store
   logic [AW-1:0] kb_mem [MAX_ITEMS];      // keys in arrival order
   logic [AW-1:0] sb_mem [MAX_ITEMS];      // keys in sorted order

   logic          cs_re, cs_we;
   logic [AW-1:0] cs_raddr, cs_waddr;
   logic [CW-1:0] cs_wdata;
   logic [CW-1:0] cs_rd_ff;
   logic          fwd_hit_ff;              // read collided with same-edge write
   logic [CW-1:0] fwd_data_ff;
   logic [CW-1:0] cnt_cur;

   logic          kb_we, kb_re;
   logic [IW-1:0] kb_waddr, kb_raddr;
   logic [AW-1:0] kb_wdata;
   logic [AW-1:0] kb_rd_ff;

   logic          sb_we, sb_re;
   logic [IW-1:0] sb_waddr, sb_raddr;
   logic [AW-1:0] sb_rd_ff;

   // ---------------------------------------------------------------- helpers
   logic          accept;
   logic          has_room;
   logic [AW-1:0] key_clip;
   logic [CW-1:0] upd_val;                 // value the update stage writes back
   logic [CW-1:0] cnt_m1;                  // item_count - 1
   logic [CW-1:0] pos_m1;                  // scatter position - 1

   assign busy     = (state_ff != cse_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign has_room = (item_cnt_ff < CW'(MAX_ITEMS));
   assign key_clip = (32'(req_data.key_value) >= 32'(KEY_SLOTS)) ?
                     LAST_SLOT : AW'(req_data.key_value);

   // current count: freshly read, or the value written on the read's own edge
   assign cnt_cur = fwd_hit_ff ? fwd_data_ff : cs_rd_ff;
   assign upd_val = st_pf_ff ? (acc_ff + cnt_cur) : (cnt_cur + CW'(1));
   assign cnt_m1  = item_cnt_ff - CW'(1);
   assign pos_m1  = cnt_cur - CW'(1);

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cse_pkg::ST_CLEAR;
         item_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
         walk_ff       <= '0;
         pf_end_ff     <= 1'b0;
         acc_ff        <= '0;
         st_vld_ff     <= 1'b0;
         st_pf_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_cnt_ff   <= item_cnt_in;
         ovf_ff        <= ovf_in;
         walk_ff       <= walk_in;
         pf_end_ff     <= pf_end_in;
         acc_ff        <= acc_in;
         st_vld_ff     <= st_vld_in;
         st_pf_ff      <= st_pf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      st_addr_ff  <= st_addr_in;
      sc_idx_ff   <= sc_idx_in;
      em_idx_ff   <= em_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in      = state_ff;
      item_cnt_in   = item_cnt_ff;
      ovf_in        = ovf_ff;
      walk_in       = walk_ff;
      pf_end_in     = pf_end_ff;
      acc_in        = acc_ff;
      st_vld_in     = 1'b0;
      st_pf_in      = 1'b0;
      st_addr_in    = st_addr_ff;
      sc_idx_in     = sc_idx_ff;
      em_idx_in     = em_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_ovf_in    = ovf_ff;

      cs_re    = 1'b0;
      cs_raddr = walk_ff;
      cs_we    = 1'b0;
      cs_waddr = st_addr_ff;
      cs_wdata = upd_val;

      kb_we    = 1'b0;
      kb_waddr = item_cnt_ff[IW-1:0];
      kb_wdata = key_clip;
      kb_re    = 1'b0;
      kb_raddr = sc_idx_ff;

      sb_we    = 1'b0;
      sb_waddr = pos_m1[IW-1:0];
      sb_re    = 1'b0;
      sb_raddr = em_idx_ff;

      // pending count update from the previous cycle's read
      if (st_vld_ff) begin
         cs_we    = 1'b1;
         cs_waddr = st_addr_ff;
         cs_wdata = upd_val;
         if (st_pf_ff) begin
            acc_in = upd_val;
         end
      end

      unique case (state_ff)
         cse_pkg::ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  kb_we       = 1'b1;
                  cs_re       = 1'b1;
                  cs_raddr    = key_clip;
                  st_vld_in   = 1'b1;
                  st_addr_in  = key_clip;
                  item_cnt_in = item_cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_key) begin
                  state_in  = cse_pkg::ST_PREFIX;
                  walk_in   = '0;
                  pf_end_in = 1'b0;
                  acc_in    = '0;
               end
            end
         end

         cse_pkg::ST_PREFIX: begin
            if (!pf_end_ff) begin
               cs_re      = 1'b1;
               cs_raddr   = walk_ff;
               st_vld_in  = 1'b1;
               st_pf_in   = 1'b1;
               st_addr_in = walk_ff;
               if (walk_ff == LAST_SLOT) begin
                  pf_end_in = 1'b1;
               end else begin
                  walk_in = walk_ff + AW'(1);
               end
            end
            if (st_vld_ff && st_pf_ff && (st_addr_ff == LAST_SLOT)) begin
               state_in  = cse_pkg::ST_SC_KEY;
               sc_idx_in = cnt_m1[IW-1:0];
            end
         end

         cse_pkg::ST_SC_KEY: begin
            kb_re    = 1'b1;
            state_in = cse_pkg::ST_SC_CNT;
         end

         cse_pkg::ST_SC_CNT: begin
            cs_re    = 1'b1;
            cs_raddr = kb_rd_ff;
            state_in = cse_pkg::ST_SC_PUT;
         end

         cse_pkg::ST_SC_PUT: begin
            if (cnt_cur != '0) begin
               sb_we    = 1'b1;
               cs_we    = 1'b1;
               cs_waddr = kb_rd_ff;
               cs_wdata = pos_m1;
            end
            if (sc_idx_ff == '0) begin
               state_in  = cse_pkg::ST_EMIT;
               em_idx_in = '0;
            end else begin
               sc_idx_in = sc_idx_ff - IW'(1);
               state_in  = cse_pkg::ST_SC_KEY;
            end
         end

         cse_pkg::ST_EMIT: begin
            sb_re         = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_last_in   = ((CW'(em_idx_ff) + CW'(1)) == item_cnt_ff);
            if (rsp_last_in) begin
               state_in = cse_pkg::ST_CLEAR;
               walk_in  = '0;
            end else begin
               em_idx_in = em_idx_ff + IW'(1);
            end
         end

         cse_pkg::ST_CLEAR: begin
            cs_we       = 1'b1;
            cs_waddr    = walk_ff;
            cs_wdata    = '0;
            item_cnt_in = '0;
            ovf_in      = 1'b0;
            if (walk_ff == LAST_SLOT) begin
               state_in = cse_pkg::ST_IDLE;
            end else begin
               walk_in = walk_ff + AW'(1);
            end
         end

         default: begin
            state_in = cse_pkg::ST_CLEAR;
            walk_in  = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- count store
   always_ff @(posedge clock) begin
      if (cs_re) begin
         cs_rd_ff <= cs_mem[cs_raddr];
      end
      if (cs_we) begin
         cs_mem[cs_waddr] <= cs_wdata;
      end
      fwd_hit_ff  <= cs_re && cs_we && (cs_raddr == cs_waddr);
      fwd_data_ff <= cs_wdata;
   end

   // ---------------------------------------------------------------- key buffer
   always_ff @(posedge clock) begin
      if (kb_re) begin
         kb_rd_ff <= kb_mem[kb_raddr];
      end
      if (kb_we) begin
         kb_mem[kb_waddr] <= kb_wdata;
      end
   end

   // ---------------------------------------------------------------- sorted buffer
   always_ff @(posedge clock) begin
      if (sb_re) begin
         sb_rd_ff <= sb_mem[sb_raddr];
      end
      if (sb_we) begin
         sb_mem[sb_waddr] <= kb_rd_ff;
      end
   end

   // ---------------------------------------------------------------- response
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.sorted_value  = cse_pkg::KEY_W'(sb_rd_ff);
   assign rsp_data.last_out      = rsp_last_ff;
   assign rsp_data.overflow      = rsp_ovf_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the counting sort engine
// Feeds sets of keys through the start/busy request port, predicts each
// sorted set with an in-bench counting sort and checks every response
// strobe, field by field, against the oldest predicted key.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SLOTS    = cse_pkg::KEY_RANGE_DEFAULT;
   localparam int CAPACITY = cse_pkg::MAX_ITEMS_DEFAULT;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   cse_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   cse_pkg::rsp_type rsp_data;

   counting_sort_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request stream waiting to go out, and sorted keys still to arrive
   cse_pkg::req_type key_queue[$];
   cse_pkg::rsp_type expected_sorted[$];

   // shadow of the engine's state
   int unsigned tally [SLOTS];
   logic [11:0] held_keys [CAPACITY];
   logic [11:0] placed [CAPACITY];
   int unsigned held_count;
   bit          dropped;

   int unsigned total_requests;
   int unsigned accepted_count;
   int unsigned keys_checked;
   int unsigned set_count;
   int unsigned overflow_sets;
   int unsigned errors;

   // Takes one accepted request into the shadow state. A last-marked
   // request runs prefix sums, stable scatter from last to first, and
   // queues the whole set in ascending order.
   task automatic tally_key(input cse_pkg::req_type r);
      int unsigned i;
      int unsigned pos;
      logic [11:0] k;
      if (held_count < CAPACITY) begin
         held_keys[held_count] = r.key_value;
         tally[r.key_value]++;
         held_count++;
      end else begin
         // set past capacity: key dropped, even a last-marked one
         dropped = 1'b1;
      end
      if (r.last_key) begin
         for (i = 1; i < SLOTS; i++)
            tally[i] += tally[i-1];
         for (i = held_count; i > 0; i--) begin
            k   = held_keys[i-1];
            pos = tally[k];
            if (pos >= 1 && pos <= CAPACITY)
               placed[pos-1] = k;
            if (pos > 0)
               tally[k] = pos - 1;
         end
         for (i = 0; i < held_count; i++)
            expected_sorted.push_back('{sorted_value: placed[i],
                                        last_out: (i + 1 == held_count),
                                        overflow: dropped});
         for (i = 0; i < SLOTS; i++)
            tally[i] = 0;
         held_count = 0;
         dropped    = 1'b0;
      end
   endtask

   // Mix of full-range keys, a narrow pool for duplicates, a top band and the edges.
   function automatic logic [11:0] pick_key();
      int unsigned mode;
      mode = $urandom_range(0, 5);
      case (mode)
         3: begin
            return 12'($urandom_range(0, 15));
         end
         4: begin
            case ($urandom_range(0, 3))
               0: return 12'd0;
               1: return 12'd4095;
               2: return 12'd1;
               default: return 12'd4094;
            endcase
         end
         5: begin
            return 12'($urandom_range(4080, 4095));
         end
         default: begin
            return 12'($urandom);
         end
      endcase
   endfunction

   task automatic queue_set(input logic [11:0] keys[$]);
      int unsigned i;
      for (i = 0; i < keys.size(); i++)
         key_queue.push_back('{key_value: keys[i], last_key: (i + 1 == keys.size())});
      total_requests += keys.size();
      set_count++;
      if (keys.size() > CAPACITY)
         overflow_sets++;
   endtask

   task automatic queue_random_set(input int unsigned size);
      logic [11:0] keys[$];
      int unsigned i;
      for (i = 0; i < size; i++)
         keys.push_back(pick_key());
      queue_set(keys);
   endtask

   // Driver: a request is taken at an edge with start high and busy low.
   // The next one is put up at the same edge unless a gap is rolled, so
   // start never drops between back-to-back requests.
   always @(posedge clock) begin
      logic             next_start;
      cse_pkg::req_type next_data;
      bit               gaps_on;
      next_start = start;
      next_data  = req_data;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && !busy) begin
            tally_key(req_data);
            accepted_count++;
            next_start = 1'b0;
         end
         // no gaps for a long stretch in the middle of the run
         gaps_on = (accepted_count < 200) || (accepted_count >= 340);
         if (!next_start && key_queue.size() > 0 &&
             !(gaps_on && $urandom_range(0, 99) < 16)) begin
            next_data  = key_queue.pop_front();
            next_start = 1'b1;
         end
      end
      start    <= next_start;
      req_data <= next_data;
   end

   // Monitor: responses cannot be stalled, so every strobe is checked.
   always @(posedge clock) begin
      cse_pkg::rsp_type want;
      bit               bad;
      if (!reset && rsp_strobe) begin
         if (expected_sorted.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual %p",
                     $time, rsp_data);
            errors++;
         end else begin
            want = expected_sorted.pop_front();
            bad  = 1'b0;
            if (rsp_data.sorted_value !== want.sorted_value) begin
               $display("%0t ns: sorted_value expected %0d actual %0d",
                        $time, want.sorted_value, rsp_data.sorted_value);
               bad = 1'b1;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $display("%0t ns: last_out expected %0b actual %0b",
                        $time, want.last_out, rsp_data.last_out);
               bad = 1'b1;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $display("%0t ns: overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_data.overflow);
               bad = 1'b1;
            end
            if (bad)
               errors++;
            keys_checked++;
         end
      end
   end

   initial begin
      int unsigned i;
      int unsigned roll;
      int unsigned size;
      for (i = 0; i < SLOTS; i++)
         tally[i] = 0;
      held_count     = 0;
      dropped        = 1'b0;
      total_requests = 0;
      accepted_count = 0;
      keys_checked   = 0;
      set_count      = 0;
      overflow_sets  = 0;
      errors         = 0;

      // directed sets: lone extremes, duplicates, alternating bit patterns
      queue_set('{12'd0});
      queue_set('{12'd4095});
      queue_set('{12'd4095, 12'd0, 12'd7, 12'd7, 12'd0, 12'd4095, 12'hAAA, 12'h555});
      queue_set('{12'd2048, 12'd1, 12'd2048, 12'd1, 12'd4094, 12'd2});
      queue_set('{12'd3, 12'd3, 12'd3, 12'd3});

      // exactly full, then past capacity with the last-marked key dropped
      queue_random_set(CAPACITY);
      queue_random_set(CAPACITY + 2);

      // random sets, mostly small, some up to capacity and a few past it
      while (total_requests < 470) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)
            size = $urandom_range(1, 8);
         else if (roll < 85)
            size = $urandom_range(9, 32);
         else if (roll < 95)
            size = ($urandom_range(0, 2) == 0) ? CAPACITY : $urandom_range(33, CAPACITY);
         else
            size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
         queue_random_set(size);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_requests)
         @(posedge clock);
      while (expected_sorted.size() != 0)
         @(posedge clock);
      // long enough for the clear sweep and any stray strobe
      repeat (5000) @(posedge clock);

      $display("covered %0d requests in %0d sets (%0d past capacity)",
               total_requests, set_count, overflow_sets);
      $display("checked %0d sorted keys, %0d bad responses", keys_checked, errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin
      #200_000_000;
      $display("timeout with %0d of %0d requests taken", accepted_count, total_requests);
      $display("status: fail");
      $finish;
   end

endmodule

// ===== counting_sort_engine.f =====
rtl/cse_pkg.sv
rtl/counting_sort_engine.sv
test/testbench.sv
